// ===== src/interval_set_coalesce_and_gap_query_top_assert.svh =====
// Assertion macros for the interval set block
`ifndef INTERVAL_SET_COALESCE_AND_GAP_QUERY_TOP_ASSERT_SVH
`define INTERVAL_SET_COALESCE_AND_GAP_QUERY_TOP_ASSERT_SVH
// Implication checked every clock outside reset
`define ISC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication
`define ISC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/isc_pkg.sv =====
// Package: types, constants and command codes for the interval set block
`default_nettype none
package isc_pkg;
  localparam int CapacityDef = 32;
  localparam int AddrBitsDef = 48;
  localparam int FieldW      = 48;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [FieldW-1:0] range_start;
    logic [FieldW-1:0] range_length;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] chunk_start;
    logic [FieldW-1:0] chunk_length;
    logic              has_chunk;
    logic              status;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FRD, ST_FCHK, ST_MRD, ST_MCHK, ST_MERGE, ST_UPRD, ST_UPWR,
    ST_DNRD, ST_DNWR, ST_QRD, ST_QCHK, ST_QEND, ST_EMIT
  } state_t;
endpackage
`default_nettype wire

// ===== src/isc_if.sv =====
// Valid/ready channel interface carrying one packed payload
`default_nettype none
interface isc_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/isc_store.sv =====
// Range store: start and end memories, one write port and one registered read port
`default_nettype none
module isc_store #(
  parameter int CAPACITY = isc_pkg::CapacityDef,
  parameter int ADDR_BITS = isc_pkg::AddrBitsDef,
  localparam int IW = $clog2(CAPACITY)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IW-1:0]        waddr,
  input  wire logic [ADDR_BITS-1:0] wstart,
  input  wire logic [ADDR_BITS-1:0] wend,
  input  wire logic [IW-1:0]        raddr,
  output      logic [ADDR_BITS-1:0] rstart,
  output      logic [ADDR_BITS-1:0] rend
);
  logic [ADDR_BITS-1:0] mem_s [CAPACITY];
  logic [ADDR_BITS-1:0] mem_e [CAPACITY];

  // write one entry, read one entry a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_s[waddr] <= wstart;
      mem_e[waddr] <= wend;
    end
    rstart <= mem_s[raddr];
    rend   <= mem_e[raddr];
  end
endmodule
`default_nettype wire

// ===== src/interval_set_coalesce_and_gap_query_top.sv =====
// Top level: sequencer over the range store
//
//  channel | dir | payload
//  in      | in  | cmd, range_start, range_length
//  out     | out | chunk_start, chunk_length, has_chunk, status, last
//
// An insert or query steps through the stored entries it visits, reads or moves
// one at a time, since the store has a single read port. Clear and other
// commands go straight to the result. Reset empties the set at once.
// Input is ready only in idle; a result waiting in the output register stalls
// the sequencer until it transfers.
`default_nettype none
module interval_set_coalesce_and_gap_query_top #(
  parameter int CAPACITY = isc_pkg::CapacityDef,
  parameter int ADDR_BITS = isc_pkg::AddrBitsDef
) (
  input wire logic clk,
  input wire logic rst,
  isc_if.sink   in,
  isc_if.source out
);
  import isc_pkg::*;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [63:0] AMax = (64'd1 << ADDR_BITS) - 64'd1;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  state_t state, state_next;
  in_item_t item_in;
  out_item_t res, res_next;
  logic res_valid, res_valid_next;
  logic drop, drop_next;
  logic out_free;
  logic [CW-1:0] count, count_next, i, i_next, j, j_next, w, w_next, wm1;
  logic [ADDR_BITS-1:0] ns, ns_next, ne, ne_next, ms, ms_next, me, me_next;
  logic [ADDR_BITS-1:0] rs, re;
  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [ADDR_BITS-1:0] wstart, wend;
  logic [63:0] s_wide, sum_wide;
  logic [ADDR_BITS-1:0] s_sat, e_sat;

  function automatic logic [FieldW-1:0] to_field(input logic [ADDR_BITS-1:0] a);
    logic [63:0] t;
    t = 64'(a);
    return t[FieldW-1:0];
  endfunction

  assign item_in = in_item_t'(in.data);
  assign in.ready = (state == ST_IDLE);
  assign out.valid = res_valid;
  assign out.data = res;
  assign out_free = !res_valid || out.ready;
  assign wm1 = w - 1'b1;

  // saturate start and end at the address limit
  always_comb begin
    s_wide = 64'(item_in.range_start);
    if (s_wide > AMax) s_wide = AMax;
    sum_wide = s_wide + 64'(item_in.range_length);
    if (sum_wide > AMax) sum_wide = AMax;
    s_sat = s_wide[ADDR_BITS-1:0];
    e_sat = sum_wide[ADDR_BITS-1:0];
  end

  isc_store #(.CAPACITY(CAPACITY), .ADDR_BITS(ADDR_BITS)) u_store (
    .clk, .we, .waddr, .wstart, .wend, .raddr, .rstart(rs), .rend(re)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      res_valid <= res_valid_next;
      count <= count_next;
    end
    res <= res_next; i <= i_next; j <= j_next; w <= w_next; drop <= drop_next;
    ns <= ns_next; ne <= ne_next; ms <= ms_next; me <= me_next;
  end

  always_comb begin
    state_next = state; res_next = res; count_next = count; drop_next = drop;
    res_valid_next = res_valid && !out.ready;
    i_next = i; j_next = j; w_next = w;
    ns_next = ns; ne_next = ne; ms_next = ms; me_next = me;
    we = 1'b0; waddr = w[IW-1:0]; wstart = rs; wend = re; raddr = i[IW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (in.valid) begin
          ns_next = s_sat; ne_next = e_sat; ms_next = s_sat;
          i_next = '0; drop_next = 1'b0;
          state_next = ST_EMIT;
          if (item_in.cmd == CMD_CLEAR) count_next = '0;
          else if (e_sat > s_sat && item_in.cmd == CMD_INSERT) state_next = ST_FRD;
          else if (e_sat > s_sat && item_in.cmd == CMD_QUERY) state_next = ST_QRD;
        end
      end
      // insert: find first entry with end >= ns
      ST_FRD: begin
        if (i < count) begin
          raddr = i[IW-1:0]; state_next = ST_FCHK;
        end else begin
          j_next = i; ms_next = ns; me_next = ne; state_next = ST_MRD;
        end
      end
      ST_FCHK: begin
        if (re < ns) begin
          i_next = i + 1'b1; state_next = ST_FRD;
        end else begin
          j_next = i; ms_next = ns; me_next = ne; state_next = ST_MCHK;
        end
      end
      // walk j over entries with start <= ne, folding them in
      ST_MRD: begin
        if (j < count) begin
          raddr = j[IW-1:0]; state_next = ST_MCHK;
        end else state_next = ST_MERGE;
      end
      ST_MCHK: begin
        if (rs <= ne) begin
          if (rs < ms) ms_next = rs;
          if (re > me) me_next = re;
          j_next = j + 1'b1; state_next = ST_MRD;
        end else state_next = ST_MERGE;
      end
      // no merge: shift up and insert unless full; else write merged range
      ST_MERGE: begin
        if (j == i) begin
          if (count >= CapC) begin
            drop_next = 1'b1; state_next = ST_EMIT;
          end else begin
            w_next = count; state_next = ST_UPRD;
          end
        end else begin
          we = 1'b1; waddr = i[IW-1:0]; wstart = ms; wend = me;
          w_next = i + 1'b1; state_next = ST_DNRD;
        end
      end
      // pull the tail down over the merged entries
      ST_DNRD: begin
        if (j < count) begin
          raddr = j[IW-1:0]; state_next = ST_DNWR;
        end else begin
          count_next = w; state_next = ST_EMIT;
        end
      end
      ST_DNWR: begin
        we = 1'b1; waddr = w[IW-1:0];
        w_next = w + 1'b1; j_next = j + 1'b1; state_next = ST_DNRD;
      end
      // shift entries up one from the top, then place the new range
      ST_UPRD: begin
        if (w == i) begin
          we = 1'b1; waddr = i[IW-1:0]; wstart = ns; wend = ne;
          count_next = count + 1'b1; state_next = ST_EMIT;
        end else begin
          raddr = wm1[IW-1:0]; state_next = ST_UPWR;
        end
      end
      ST_UPWR: begin
        we = 1'b1; waddr = w[IW-1:0];
        w_next = wm1; state_next = ST_UPRD;
      end
      // query: ms is the cursor, ne the end
      ST_QRD: begin
        if (i < count && ms < ne) begin
          raddr = i[IW-1:0]; state_next = ST_QCHK;
        end else state_next = ST_QEND;
      end
      ST_QCHK: begin
        if (re <= ms) begin
          i_next = i + 1'b1; state_next = ST_QRD;
        end else if (rs >= ne) begin
          state_next = ST_QEND;
        end else if (rs > ms) begin
          // gap before this entry; stored ranges never touch, so it is the
          // final chunk exactly when this entry reaches the query end
          if (out_free) begin
            res_next = '{chunk_start: to_field(ms), chunk_length: to_field(rs - ms),
                         has_chunk: 1'b1, status: 1'b0, last: (re >= ne)};
            res_valid_next = 1'b1;
            ms_next = re; i_next = i + 1'b1;
            state_next = (re >= ne) ? ST_IDLE : ST_QRD;
          end
        end else begin
          ms_next = re; i_next = i + 1'b1; state_next = ST_QRD;
        end
      end
      ST_QEND: begin
        if (out_free) begin
          if (ms < ne)
            res_next = '{chunk_start: to_field(ms), chunk_length: to_field(ne - ms),
                         has_chunk: 1'b1, status: 1'b0, last: 1'b1};
          else
            res_next = '{chunk_start: '0, chunk_length: '0, has_chunk: 1'b0,
                         status: 1'b0, last: 1'b1};
          res_valid_next = 1'b1; state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          res_next = '{chunk_start: '0, chunk_length: '0, has_chunk: 1'b0,
                       status: drop, last: 1'b1};
          res_valid_next = 1'b1; state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/isc_checker.sv =====
// Port-level checker for the interval set block, bound to the top level
`default_nettype none
`include "interval_set_coalesce_and_gap_query_top_assert.svh"
module isc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic has_chunk,
  input wire logic status,
  input wire logic last
);
  `ISC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ISC_ASSERT_IMP(a_status_empty, clk, rst, out_valid && status, !has_chunk && last)
  `ISC_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
endmodule
bind interval_set_coalesce_and_gap_query_top isc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .has_chunk(out.data[2]), .status(out.data[1]), .last(out.data[0])
);
`default_nettype wire
